// ----- design/mk_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mk_pkg
// Shared types, phase codes and the letter table of the Morse keyer.
// ----------------------------------------------------------------------------
package mk_pkg;

    localparam int unsigned UNIT_W = 16;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_MARK = 3'd1;
    localparam logic [2:0] PH_EGAP = 3'd2;
    localparam logic [2:0] PH_LGAP = 3'd3;
    localparam logic [2:0] PH_WGAP = 3'd4;

    localparam logic [UNIT_W-1:0] DEFAULT_UNIT     = 16'd250;
    localparam logic [2:0]        DASH_UNITS       = 3'd3;
    localparam logic [2:0]        LETTER_GAP_UNITS = 3'd3;
    localparam logic [2:0]        WORD_GAP_UNITS   = 3'd4;

    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z = 8'h7a;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic [3:0]        pattern;
        logic [2:0]        elements_left;
        logic [2:0]        phase;
        logic [UNIT_W-1:0] tick_count;
        logic [2:0]        units_left;
    } mk_state_t;

    typedef struct packed {
        logic key_on;
        logic busy_res;
        logic char_accepted;
    } mk_result_t;

    // length in bits 6..4, marks in bits 3..0, bit 0 sent first, 1 = dash
    function automatic logic [6:0] letter_code(input logic [4:0] idx);
        logic [6:0] code;
        unique case (idx)
            5'd0:    code = 7'h22;
            5'd1:    code = 7'h41;
            5'd2:    code = 7'h45;
            5'd3:    code = 7'h31;
            5'd4:    code = 7'h10;
            5'd5:    code = 7'h44;
            5'd6:    code = 7'h33;
            5'd7:    code = 7'h40;
            5'd8:    code = 7'h20;
            5'd9:    code = 7'h4e;
            5'd10:   code = 7'h35;
            5'd11:   code = 7'h42;
            5'd12:   code = 7'h23;
            5'd13:   code = 7'h21;
            5'd14:   code = 7'h37;
            5'd15:   code = 7'h46;
            5'd16:   code = 7'h4b;
            5'd17:   code = 7'h32;
            5'd18:   code = 7'h30;
            5'd19:   code = 7'h11;
            5'd20:   code = 7'h34;
            5'd21:   code = 7'h48;
            5'd22:   code = 7'h36;
            5'd23:   code = 7'h49;
            5'd24:   code = 7'h4d;
            5'd25:   code = 7'h43;
            default: code = 7'h00;
        endcase
        return code;
    endfunction

endpackage

// ----- design/mk_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mk_req_if
// Request channel: a character or a tick item.
// ----------------------------------------------------------------------------
interface mk_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] char_code;

    modport source (output valid, output req_type, output char_code, input ready);
    modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

// ----- design/mk_res_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mk_res_if
// Result channel: key level and status after each item.
// ----------------------------------------------------------------------------
interface mk_res_if;
    logic valid;
    logic ready;
    logic key_on;
    logic busy_res;
    logic char_accepted;

    modport source (output valid, output key_on, output busy_res, output char_accepted,
                    input ready);
    modport sink   (input valid, input key_on, input busy_res, input char_accepted,
                    output ready);
endinterface

// ----- design/mk_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mk_cfg_if
// Configuration write channel for the unit length register.
// ----------------------------------------------------------------------------
interface mk_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/morse_keyer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_keyer_core
// International Morse keyer: lowercase letters and space in, key line out.
//
// Each request is a character or one time tick, and every request gives
// exactly one result with the key level, the busy flag and whether the
// character was taken. A request passes an input register and then the
// step logic into the result register, one request per clock when the
// result side keeps up. A dot is one unit on, a dash three, element gaps
// one unit, letter gaps three and a space four more, where a unit is
// unit_ticks tick requests (zero counts as one). Characters that arrive
// while busy, and codes other than a to z and space, are not taken.
// Write unit_ticks only while the keyer is idle.
// ----------------------------------------------------------------------------
module morse_keyer_core (
    input  logic      clk,
    input  logic      rst_n,
    mk_req_if.sink    req,
    mk_res_if.source  res,
    mk_cfg_if.sink    cfg
);

    logic                      s1_valid_reg;
    logic                      s1_type_reg;
    logic [7:0]                s1_char_reg;
    logic                      out_valid_reg;
    mk_pkg::mk_result_t        out_reg;
    mk_pkg::mk_state_t         state_reg;
    mk_pkg::mk_state_t         state_next;
    mk_pkg::mk_result_t        result_next;
    logic [mk_pkg::UNIT_W-1:0] unit_reg;
    logic                      s2_advance;

    assign s2_advance = s1_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready  = !s1_valid_reg || s2_advance;
    assign cfg.ready  = 1'b1;

    mk_step u_step (
        .cur        (state_reg),
        .unit_ticks (unit_reg),
        .req_type   (s1_type_reg),
        .char_code  (s1_char_reg),
        .nxt        (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg <= mk_pkg::DEFAULT_UNIT;
        end
        else if (cfg.valid)
        begin
            unit_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_type_reg <= req.req_type;
            s1_char_reg <= req.char_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_advance)
        begin
            out_reg <= result_next;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.key_on        = out_reg.key_on;
    assign res.busy_res      = out_reg.busy_res;
    assign res.char_accepted = out_reg.char_accepted;

`ifndef NO_ASSERTIONS
    // idle keyer holds no leftover marks or units
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == mk_pkg::PH_IDLE) |->
            (state_reg.pattern == 4'd0 && state_reg.elements_left == 3'd0 &&
             state_reg.units_left == 3'd0))
        else $error("idle keyer has leftover state");

    // a busy phase always has units to run
    a_busy_units: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase != mk_pkg::PH_IDLE) |->
            (state_reg.units_left != 3'd0 && state_reg.phase <= mk_pkg::PH_WGAP))
        else $error("busy phase without units or with bad code");

    // a taken character or a keyed line means busy
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.char_accepted || out_reg.key_on)) |-> out_reg.busy_res)
        else $error("result keyed or accepted while not busy");

    // the keyer state only changes when an item leaves the input register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s2_advance |=> $stable(state_reg))
        else $error("keyer state changed without a request");
`endif

endmodule

// ----- design/mk_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mk_step
// Next keyer state and result for one character or tick item.
// ----------------------------------------------------------------------------
module mk_step (
    input  mk_pkg::mk_state_t              cur,
    input  logic [mk_pkg::UNIT_W-1:0]      unit_ticks,
    input  logic                           req_type,
    input  logic [7:0]                     char_code,
    output mk_pkg::mk_state_t              nxt,
    output mk_pkg::mk_result_t             result
);

    logic [mk_pkg::UNIT_W-1:0] unit_len;
    logic [mk_pkg::UNIT_W:0]   tick_inc;
    logic [2:0]                units_dec;
    logic [2:0]                elems_dec;
    logic [3:0]                pat_shift;
    logic [6:0]                code;
    logic [7:0]                letter_off;
    logic                      is_letter;
    logic                      accepted;

    assign unit_len   = (unit_ticks == '0) ? mk_pkg::UNIT_W'(1) : unit_ticks;
    assign tick_inc   = {1'b0, cur.tick_count} + (mk_pkg::UNIT_W+1)'(1);
    assign units_dec  = cur.units_left - 3'd1;
    assign elems_dec  = cur.elements_left - 3'd1;
    assign pat_shift  = {1'b0, cur.pattern[3:1]};
    assign letter_off = char_code - mk_pkg::CHAR_LOW_A;
    assign code       = mk_pkg::letter_code(letter_off[4:0]);
    assign is_letter  = (char_code >= mk_pkg::CHAR_LOW_A) && (char_code <= mk_pkg::CHAR_LOW_Z);

    always_comb
    begin
        nxt      = cur;
        accepted = 1'b0;
        if (req_type == mk_pkg::REQ_CHAR)
        begin
            if (cur.phase == mk_pkg::PH_IDLE)
            begin
                if (is_letter)
                begin
                    nxt.pattern       = code[3:0];
                    nxt.elements_left = code[6:4];
                    nxt.phase         = mk_pkg::PH_MARK;
                    nxt.units_left    = code[0] ? mk_pkg::DASH_UNITS : 3'd1;
                    nxt.tick_count    = '0;
                    accepted          = 1'b1;
                end
                else if (char_code == mk_pkg::CHAR_SPACE)
                begin
                    nxt.pattern       = '0;
                    nxt.elements_left = '0;
                    nxt.phase         = mk_pkg::PH_WGAP;
                    nxt.units_left    = mk_pkg::WORD_GAP_UNITS;
                    nxt.tick_count    = '0;
                    accepted          = 1'b1;
                end
            end
        end
        else if (cur.phase != mk_pkg::PH_IDLE)
        begin
            if (tick_inc >= {1'b0, unit_len})
            begin
                nxt.tick_count = '0;
                nxt.units_left = units_dec;
                if (units_dec == 3'd0)
                begin
                    // unit count ran out: move to the next phase
                    if (cur.phase == mk_pkg::PH_MARK)
                    begin
                        nxt.elements_left = elems_dec;
                        nxt.pattern       = pat_shift;
                        if (elems_dec != 3'd0)
                        begin
                            nxt.phase      = mk_pkg::PH_EGAP;
                            nxt.units_left = 3'd1;
                        end
                        else
                        begin
                            nxt.phase      = mk_pkg::PH_LGAP;
                            nxt.units_left = mk_pkg::LETTER_GAP_UNITS;
                        end
                    end
                    else if (cur.phase == mk_pkg::PH_EGAP)
                    begin
                        nxt.phase      = mk_pkg::PH_MARK;
                        nxt.units_left = cur.pattern[0] ? mk_pkg::DASH_UNITS : 3'd1;
                    end
                    else
                    begin
                        nxt.phase         = mk_pkg::PH_IDLE;
                        nxt.units_left    = '0;
                        nxt.pattern       = '0;
                        nxt.elements_left = '0;
                    end
                end
            end
            else
            begin
                nxt.tick_count = tick_inc[mk_pkg::UNIT_W-1:0];
            end
        end
    end

    assign result.key_on        = (nxt.phase == mk_pkg::PH_MARK);
    assign result.busy_res      = (nxt.phase != mk_pkg::PH_IDLE);
    assign result.char_accepted = accepted;

endmodule
